[sv/mcsa_pkg.sv]
`timescale 1ns / 1ps

package mcsa_pkg;

  localparam int PORT_COUNT_DEF = 16;
  localparam int CH_PER_PORT = 16;

  localparam logic [3:0] DRUM_CHANNEL = 4'd9;
  localparam logic [15:0] NON_DRUM_MASK = ~(16'd1 << DRUM_CHANNEL);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_MARK = 2'd1;
  localparam logic [1:0] CMD_ALLOC = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] req_port;
    logic [3:0] req_channel;
    logic       port_given;
    logic       channel_given;
    logic       drum;
  } req_t;

  typedef struct packed {
    logic [3:0] slot_port;
    logic [3:0] slot_channel;
    logic       status;
  } rsp_t;

  // What the latched request asks for, once decoded.
  typedef enum logic [2:0] {
    K_CLEAR,
    K_NOP,
    K_MARK,
    K_BADMARK,
    K_FIXED,
    K_CHAN,
    K_PORT,
    K_GLOBAL
  } kind_t;

  typedef enum logic [1:0] {
    MODE_MARK,
    MODE_CHAN,
    MODE_PORT,
    MODE_GLOBAL
  } mode_t;

  typedef enum logic [1:0] {
    RES_OK_ZERO,
    RES_FAIL,
    RES_FIXED,
    RES_FOUND
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     scan_start;
    mode_t    start_mode;
    mode_t    mode;
    logic     step;
    logic     commit;
    logic     ptr_end;
    logic     emit;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  found;
    logic  exhausted;
  } dp_stat_t;

endpackage

[sv/mcsa_ram.sv]
`timescale 1ns / 1ps

module mcsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/mcsa_ctrl.sv]
`timescale 1ns / 1ps

module mcsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mcsa_pkg::dp_stat_t stat,
  output mcsa_pkg::dp_cmd_t  cmd
);

  import mcsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECODE = 3'b010,
    S_SCAN   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.mode  = mode_r;
    state_nxt = state_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          K_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_OK_ZERO;
            state_nxt   = S_IDLE;
          end
          K_NOP: begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_OK_ZERO;
            state_nxt   = S_IDLE;
          end
          K_BADMARK: begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_FAIL;
            state_nxt   = S_IDLE;
          end
          K_FIXED: begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_FIXED;
            state_nxt   = S_IDLE;
          end
          K_MARK: begin
            cmd.scan_start = 1'b1;
            cmd.start_mode = MODE_MARK;
            mode_nxt       = MODE_MARK;
            state_nxt      = S_SCAN;
          end
          K_CHAN: begin
            cmd.scan_start = 1'b1;
            cmd.start_mode = MODE_CHAN;
            mode_nxt       = MODE_CHAN;
            state_nxt      = S_SCAN;
          end
          K_PORT: begin
            cmd.scan_start = 1'b1;
            cmd.start_mode = MODE_PORT;
            mode_nxt       = MODE_PORT;
            state_nxt      = S_SCAN;
          end
          default: begin
            cmd.scan_start = 1'b1;
            cmd.start_mode = MODE_GLOBAL;
            mode_nxt       = MODE_GLOBAL;
            state_nxt      = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.found) begin
          cmd.commit  = 1'b1;
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_FOUND;
          state_nxt   = S_IDLE;
        end else if (stat.exhausted) begin
          if (mode_r == MODE_PORT) begin
            // A full port falls back to the global search.
            cmd.scan_start = 1'b1;
            cmd.start_mode = MODE_GLOBAL;
            mode_nxt       = MODE_GLOBAL;
          end else begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_FAIL;
            cmd.ptr_end = (mode_r == MODE_GLOBAL);
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_GLOBAL;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule

[sv/mcsa_dp.sv]
`timescale 1ns / 1ps

module mcsa_dp #(
  parameter int PORT_COUNT = mcsa_pkg::PORT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mcsa_pkg::req_t     in_req,
  input  mcsa_pkg::dp_cmd_t  cmd,
  output mcsa_pkg::dp_stat_t stat,
  output logic               out_valid,
  output mcsa_pkg::rsp_t     out_rsp
);

  import mcsa_pkg::*;

  localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int SLOT_TOTAL = PORT_COUNT * CH_PER_PORT;
  localparam int PTR_W = $clog2(SLOT_TOTAL + 1);
  localparam int RW = PTR_W - 4;
  localparam logic [RW-1:0] ROW_END = RW'(PORT_COUNT);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(SLOT_TOTAL);

  function automatic logic [3:0] lowest_set(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  req_t                  req_r;
  rsp_t                  out_rsp_r, rsp_nxt;
  logic                  out_valid_r;
  logic [PTR_W-1:0]      ptr_r;
  logic [PORT_COUNT-1:0] row_valid_r;
  logic [RW-1:0]         rd_row_r, scan_end_r, chk_row_r;
  logic                  chk_v_r;

  logic [15:0] ram_rdata, row_bits, mask, free_bits, wdata;
  logic [3:0]  scan_ch, hit_bit, grant_ch;
  logic        port_ok, hit, issue, first_row;
  logic [RW-1:0] start_row, start_end;
  kind_t       kind;

  assign port_ok = 32'(req_r.req_port) < PORT_COUNT;
  assign scan_ch = req_r.drum ? DRUM_CHANNEL : req_r.req_channel;

  always_comb begin
    unique case (req_r.cmd)
      CMD_CLEAR: kind = K_CLEAR;
      CMD_MARK:  kind = port_ok ? K_MARK : K_BADMARK;
      CMD_ALLOC: begin
        if (req_r.drum) begin
          kind = K_CHAN;
        end else if (req_r.port_given && req_r.channel_given) begin
          kind = K_FIXED;
        end else if (req_r.channel_given) begin
          kind = K_CHAN;
        end else if (req_r.port_given && port_ok) begin
          kind = K_PORT;
        end else begin
          kind = K_GLOBAL;
        end
      end
      default:   kind = K_NOP;
    endcase
  end

  // A row never written since the last clear reads as all free.
  assign row_bits  = row_valid_r[chk_row_r[PW-1:0]] ? ram_rdata : '0;
  assign first_row = (chk_row_r == ptr_r[PTR_W-1:4]);

  always_comb begin
    unique case (cmd.mode)
      MODE_CHAN:   mask = 16'd1 << scan_ch;
      MODE_PORT:   mask = NON_DRUM_MASK;
      MODE_GLOBAL: mask = NON_DRUM_MASK & (first_row ? (16'hFFFF << ptr_r[3:0]) : 16'hFFFF);
      default:     mask = 16'hFFFF;
    endcase
  end

  assign free_bits = ~row_bits & mask;
  assign hit       = |free_bits;
  assign hit_bit   = lowest_set(free_bits);
  assign grant_ch  = (cmd.mode == MODE_MARK) ? req_r.req_channel : hit_bit;
  assign wdata     = row_bits | (16'd1 << grant_ch);
  assign issue     = cmd.step && (rd_row_r < scan_end_r);

  assign stat.kind      = kind;
  assign stat.found     = chk_v_r && ((cmd.mode == MODE_MARK) || hit);
  assign stat.exhausted = !chk_v_r && !(rd_row_r < scan_end_r);

  always_comb begin
    unique case (cmd.start_mode)
      MODE_CHAN: begin
        start_row = '0;
        start_end = ROW_END;
      end
      MODE_GLOBAL: begin
        start_row = ptr_r[PTR_W-1:4];
        start_end = ROW_END;
      end
      default: begin
        start_row = RW'(req_r.req_port);
        start_end = RW'(req_r.req_port) + RW'(1);
      end
    endcase
  end

  always_comb begin
    rsp_nxt = '0;
    case (cmd.res_sel)
      RES_FAIL: rsp_nxt.status = 1'b1;
      RES_FIXED: begin
        rsp_nxt.slot_port    = req_r.req_port;
        rsp_nxt.slot_channel = req_r.req_channel;
      end
      RES_FOUND: begin
        rsp_nxt.slot_port    = (cmd.mode == MODE_MARK) ? 4'd0 : 4'(chk_row_r);
        rsp_nxt.slot_channel = (cmd.mode == MODE_MARK) ? 4'd0 : grant_ch;
      end
      default: rsp_nxt = '0;
    endcase
  end

  mcsa_ram #(
    .WIDTH(CH_PER_PORT),
    .DEPTH(PORT_COUNT)
  ) u_map (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(chk_row_r[PW-1:0]),
    .wdata(wdata),
    .raddr(rd_row_r[PW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.emit) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      row_valid_r <= '0;
      rd_row_r    <= '0;
      scan_end_r  <= '0;
      chk_row_r   <= '0;
      chk_v_r     <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.clear) begin
        row_valid_r <= '0;
        ptr_r       <= '0;
      end
      if (cmd.commit) begin
        row_valid_r[chk_row_r[PW-1:0]] <= 1'b1;
        if (cmd.mode == MODE_GLOBAL) begin
          ptr_r <= {chk_row_r, grant_ch};
        end
      end
      if (cmd.ptr_end) begin
        ptr_r <= PTR_END;
      end
      if (cmd.scan_start) begin
        rd_row_r   <= start_row;
        scan_end_r <= start_end;
        chk_v_r    <= 1'b0;
      end else if (issue) begin
        rd_row_r  <= rd_row_r + RW'(1);
        chk_row_r <= rd_row_r;
        chk_v_r   <= 1'b1;
      end else begin
        chk_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_END)
    else $error("search pointer beyond the last slot");

  a_commit_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> chk_v_r)
    else $error("map write without a checked row");

  a_chk_row: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> (chk_row_r < ROW_END))
    else $error("checked row outside the map");

endmodule

[sv/midi_channel_slot_allocator_core.sv]
`timescale 1ns / 1ps

// Slot allocator over a port*16+channel occupancy map.
// A request is taken at a rising edge where start is high and busy is low;
// in_req carries the command (clear, mark, allocate) and its fields. busy
// stays high until the answer has been decided, and each request produces
// exactly one answer on out_rsp, shown for one cycle with out_valid high.
// The receiver cannot hold answers off. busy falls as the answer is shown,
// so the next request can be taken at the edge that takes the answer.
// Clear, bad mark, unused command and fixed-slot requests are answered from
// the decode state without a map read. Marks and scans read one port row of
// 16 slots per cycle from the map memory: an answer found in a row is decided
// as soon as that row has been checked, and a scan that finds nothing answers
// once its last row has been checked (with no row read at all when the search
// pointer has already run past the last slot). A port-given request on a full
// port then runs the global search.
// Reset, like a clear request, empties the map through per-row valid bits
// at once and returns the search pointer to slot zero; no sweep is needed.

module midi_channel_slot_allocator_core #(
  parameter int PORT_COUNT = mcsa_pkg::PORT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mcsa_pkg::req_t in_req,
  output logic           out_valid,
  output mcsa_pkg::rsp_t out_rsp
);

  import mcsa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcsa_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  mcsa_dp #(
    .PORT_COUNT(PORT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_answer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("answer shown while a request is still in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status) |->
      (out_rsp.slot_port == 4'd0 && out_rsp.slot_channel == 4'd0))
    else $error("failed answer carries a slot");

endmodule
